// ----- hdl/swst_pkg.sv -----
// swst_pkg: shared types and constants of the sliding window slot tracker
// no dependencies; imported by sliding_window_slot_tracker_top

package swst_pkg;

	// width of the window size register and of the modulo remainder
	localparam int WIN_W = 5;

	// sequence bits folded into the remainder per modulo step
	localparam int DIGIT_BITS = 4;

	// register index decode on paddr[2]
	localparam logic REG_WINDOW = 1'b0;

	// request codes
	localparam logic REQ_ADD    = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_APPLY,
		ST_WALK,
		ST_RESULT
	} swst_state_t;

endpackage

// ----- hdl/sliding_window_slot_tracker_top.sv -----
// sliding_window_slot_tracker_top: slot table, counters and sequencer of the tracker
// one item at a time, the next is taken in the cycle after the result is loaded.
// the modulo unit folds 4 sequence bits per cycle, and when a remove of the lowest
// sequence walks the table, the walk checks one slot per cycle.
// reset: window size 16, highest = 15, lowest = current = 0, all slots invalid.

module sliding_window_slot_tracker_top
	import swst_pkg::*;
#(
	parameter int MAX_WINDOW = 16,
	parameter int SEQ_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [31:0] seq_num,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        removed,
	output logic [31:0] lowest_seq,
	output logic [31:0] highest_seq,
	output logic [31:0] current_seq
);

	// the 5-bit window register never asks for more than 31 slots
	localparam int SLOTS     = (MAX_WINDOW < 31) ? MAX_WINDOW : 31;
	localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int RESET_WIN = (SLOTS < 16) ? SLOTS : 16;
	localparam int STEPS     = (SEQ_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int PAD_W     = STEPS * DIGIT_BITS;
	localparam int CNT_W     = ($clog2(STEPS + 1) > WIN_W + 1) ? $clog2(STEPS + 1) : WIN_W + 1;
	localparam logic [SEQ_BITS-1:0] SEQ_MAX = '1;

	swst_state_t state_q, state_d;

	// control state
	logic [WIN_W-1:0]    win_q;
	logic [SEQ_BITS-1:0] highest_q;
	logic [SEQ_BITS-1:0] lowest_q;
	logic [SEQ_BITS-1:0] current_q;
	logic [SLOTS-1:0]    valid_q;
	logic                out_valid_q;

	// item working registers
	logic                req_q;
	logic [SEQ_BITS-1:0] seq_q;
	logic [PAD_W-1:0]    mod_sh_q;
	logic [WIN_W-1:0]    rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    widx_q;
	logic                rm_q;
	logic [SEQ_BITS-1:0] tag_q [SLOTS];

	// result registers
	logic                removed_q;
	logic [31:0]         lowest_out_q;
	logic [31:0]         highest_out_q;
	logic [31:0]         current_out_q;

	logic                cfg_wr;
	logic [WIN_W-1:0]    cfg_raw;
	logic [WIN_W-1:0]    cfg_win;
	logic [SEQ_BITS-1:0] seq_in;
	logic [WIN_W-1:0]    rem_next;
	logic [DIGIT_BITS-1:0] digit;
	logic [WIN_W:0]      trial;
	logic [IDX_W-1:0]    idx;
	logic                rm_hit;
	logic                walk_end;
	logic                valid_w;
	logic                walk_stop;
	logic [SEQ_BITS-1:0] cmp_a;
	logic                cmp_gt;
	logic [SEQ_BITS-1:0] inc_in;
	logic [SEQ_BITS-1:0] inc_out;
	logic [WIN_W-1:0]    widx_inc;
	logic [IDX_W-1:0]    widx_next;
	logic                out_load;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_WINDOW);
	assign cfg_raw = pwdata[WIN_W-1:0];
	assign prdata  = (paddr[2] == REG_WINDOW) ? 32'(win_q) : '0;

	always_comb begin
		if (cfg_raw == '0) begin
			cfg_win = WIN_W'(1);
		end else if (cfg_raw > WIN_W'(SLOTS)) begin
			cfg_win = WIN_W'(SLOTS);
		end else begin
			cfg_win = cfg_raw;
		end
	end

	assign seq_in = SEQ_BITS'(seq_num);

	// modulo step: fold one digit into the remainder, compare and subtract per bit
	assign digit = mod_sh_q[PAD_W-1 -: DIGIT_BITS];

	always_comb begin
		rem_next = rem_q;
		trial    = '0;
		for (int k = DIGIT_BITS - 1; k >= 0; k--) begin
			trial = {rem_next, digit[k]};
			if (trial >= {1'b0, win_q}) begin
				trial = trial - {1'b0, win_q};
			end
			rem_next = trial[WIN_W-1:0];
		end
	end

	assign idx    = rem_q[IDX_W-1:0];
	assign rm_hit = (req_q == REQ_REMOVE) && valid_q[idx] && (tag_q[idx] == seq_q);

	// walk controls
	assign walk_end  = (cnt_q == CNT_W'(win_q));
	assign valid_w   = valid_q[widx_q];
	assign widx_inc  = WIN_W'(widx_q) + WIN_W'(1);
	assign widx_next = (widx_inc == win_q) ? '0 : widx_inc[IDX_W-1:0];

	// shared compare and saturating increment
	assign cmp_a   = (state_q == ST_WALK) ? lowest_q : seq_q;
	assign cmp_gt  = cmp_a > highest_q;

	always_comb begin
		if (state_q == ST_APPLY) begin
			inc_in = current_q;
		end else if (walk_end) begin
			inc_in = highest_q;
		end else begin
			inc_in = lowest_q;
		end
	end

	assign inc_out   = (inc_in == SEQ_MAX) ? SEQ_MAX : inc_in + SEQ_BITS'(1);
	assign walk_stop = walk_end || cmp_gt || valid_w || (lowest_q == SEQ_MAX);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				if (cnt_q == '0) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (rm_hit && (seq_q == lowest_q)) begin
					state_d = ST_WALK;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_WALK: begin
				if (walk_stop) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// window, counters, valid bits and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= WIN_W'(RESET_WIN);
			highest_q   <= SEQ_BITS'(RESET_WIN - 1);
			lowest_q    <= '0;
			current_q   <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && out_stall);
			if (cfg_wr) begin
				win_q     <= cfg_win;
				highest_q <= SEQ_BITS'(cfg_win) - SEQ_BITS'(1);
				lowest_q  <= '0;
				current_q <= '0;
				valid_q   <= '0;
			end else if (state_q == ST_APPLY) begin
				if (req_q == REQ_ADD) begin
					valid_q[idx] <= 1'b1;
					if (cmp_gt) begin
						highest_q <= seq_q;
					end
					if (seq_q == current_q) begin
						current_q <= inc_out;
					end
				end else if (rm_hit) begin
					valid_q[idx] <= 1'b0;
				end
			end else if (state_q == ST_WALK) begin
				// a full lap over free slots jumps straight past highest
				if (walk_end) begin
					if (!cmp_gt && !valid_w) begin
						lowest_q <= inc_out;
					end
				end else if (!walk_stop) begin
					lowest_q <= inc_out;
				end
			end
		end
	end

	// item working registers, tags and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					req_q    <= req_type;
					seq_q    <= seq_in;
					mod_sh_q <= PAD_W'(seq_in);
					rem_q    <= '0;
					cnt_q    <= CNT_W'(STEPS - 1);
				end
			end
			ST_MOD: begin
				rem_q    <= rem_next;
				mod_sh_q <= mod_sh_q << DIGIT_BITS;
				cnt_q    <= cnt_q - CNT_W'(1);
			end
			ST_APPLY: begin
				if (req_q == REQ_ADD) begin
					tag_q[idx] <= seq_q;
				end
				rm_q   <= rm_hit;
				widx_q <= idx;
				cnt_q  <= '0;
			end
			ST_WALK: begin
				if (!walk_stop) begin
					widx_q <= widx_next;
					cnt_q  <= cnt_q + CNT_W'(1);
				end
			end
			ST_RESULT: begin
				if (out_load) begin
					removed_q     <= rm_q;
					lowest_out_q  <= 32'(lowest_q);
					highest_out_q <= 32'(highest_q);
					current_out_q <= 32'(current_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign removed     = removed_q;
	assign lowest_seq  = lowest_out_q;
	assign highest_seq = highest_out_q;
	assign current_seq = current_out_q;

	// lowest never runs more than one past highest
	a_lowest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, lowest_q} <= ({1'b0, highest_q} + (SEQ_BITS + 1)'(1)))
		else $error("lowest counter passed highest plus one");

	// remainder stays inside the window while folding
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOD) |-> (rem_q < win_q))
		else $error("modulo remainder out of range");

	// the walk never visits more slots than the window holds
	a_walk_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (cnt_q <= CNT_W'(win_q)))
		else $error("walk ran past the window");

endmodule

// ----- bench/tb_sliding_window_slot_tracker_top.sv -----
// tb_sliding_window_slot_tracker_top: self-checking bench for the slot tracker
// depends on swst_pkg and sliding_window_slot_tracker_top; drives requests, window
// size writes and result stalls, and checks every result against its own tracker
`timescale 1ns / 1ps

module tb_sliding_window_slot_tracker_top;
	import swst_pkg::*;

	localparam int          SLOTS   = 16;
	localparam logic [31:0] SEQ_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        kind;
		logic [31:0] seq;
	} request_t;

	typedef struct packed {
		logic        removed;
		logic [31:0] lowest;
		logic [31:0] highest;
		logic [31:0] current;
	} counters_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        req_type = REQ_ADD;
	logic [31:0] seq_num = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        removed;
	logic [31:0] lowest_seq;
	logic [31:0] highest_seq;
	logic [31:0] current_seq;

	sliding_window_slot_tracker_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.seq_num     (seq_num),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.removed     (removed),
		.lowest_seq  (lowest_seq),
		.highest_seq (highest_seq),
		.current_seq (current_seq)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// tracker state
	logic        slot_live [SLOTS];
	logic [31:0] slot_owner [SLOTS];
	logic [31:0] hi_mark;
	logic [31:0] lo_mark;
	logic [31:0] cur_mark;
	logic [4:0]  win_slots;

	counters_t   expected_counters [$];
	request_t    pending_reqs [$];
	request_t    next_req;
	logic        req_taken = 1'b0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int          mismatches = 0;

	// sender-side view used to shape the traffic
	logic [31:0] in_flight [$];
	logic [31:0] next_send;
	logic [31:0] last_acked;
	int          send_window;

	function automatic logic [4:0] clamp_window(logic [4:0] v);
		if (v == 0)
			return 5'd1;
		if (v > SLOTS)
			return 5'(SLOTS);
		return v;
	endfunction

	function automatic void restart_tracker(logic [4:0] size);
		win_slots = clamp_window(size);
		for (int i = 0; i < SLOTS; i++) begin
			slot_live[i] = 1'b0;
			slot_owner[i] = '0;
		end
		hi_mark = 32'(win_slots) - 1;
		lo_mark = '0;
		cur_mark = '0;
		in_flight.delete();
		next_send = '0;
		last_acked = '0;
		send_window = int'(win_slots);
	endfunction

	// step lowest past freed slots, at most one window's worth; a full lap over free slots jumps past highest
	function automatic void advance_lowest();
		for (int i = 0; i < win_slots; i++) begin
			if (lo_mark > hi_mark || slot_live[4'(lo_mark % win_slots)] || lo_mark == SEQ_MAX)
				return;
			lo_mark++;
		end
		if (lo_mark <= hi_mark && !slot_live[4'(lo_mark % win_slots)])
			lo_mark = (hi_mark == SEQ_MAX) ? SEQ_MAX : hi_mark + 1;
	endfunction

	function automatic void track_request(logic kind, logic [31:0] seq);
		logic [3:0]  slot;
		counters_t   c;
		slot = 4'(seq % win_slots);
		c.removed = 1'b0;
		if (kind == REQ_ADD) begin
			slot_live[slot] = 1'b1;
			slot_owner[slot] = seq;
			if (seq > hi_mark)
				hi_mark = seq;
			if (seq == cur_mark && cur_mark != SEQ_MAX)
				cur_mark++;
		end else if (slot_live[slot] && slot_owner[slot] == seq) begin
			slot_live[slot] = 1'b0;
			c.removed = 1'b1;
			if (seq == lo_mark)
				advance_lowest();
		end
		c.lowest = lo_mark;
		c.highest = hi_mark;
		c.current = cur_mark;
		expected_counters.push_back(c);
	endfunction

	task automatic check_field(string label, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t mismatch on %s: expected %h, actual %h", $time, label, want, got);
			mismatches++;
		end
	endtask

	// driver: items change on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || req_taken) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_req = pending_reqs.pop_front();
				in_valid <= 1'b1;
				req_type <= next_req.kind;
				seq_num <= next_req.seq;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// monitor: both handshakes sampled on the rising edge
	always @(posedge clk) begin
		counters_t want;
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall)
				track_request(req_type, seq_num);
			if (out_valid && !out_stall) begin
				if (expected_counters.size() == 0) begin
					$display("%0t unexpected result: expected none, actual %b %h %h %h",
						$time, removed, lowest_seq, highest_seq, current_seq);
					mismatches++;
				end else begin
					want = expected_counters.pop_front();
					check_field("removed", 32'(want.removed), 32'(removed));
					check_field("lowest_seq", want.lowest, lowest_seq);
					check_field("highest_seq", want.highest, highest_seq);
					check_field("current_seq", want.current, current_seq);
				end
			end
		end
	end

	task automatic push_req(logic kind, logic [31:0] seq);
		request_t r;
		r.kind = kind;
		r.seq = seq;
		pending_reqs.push_back(r);
	endtask

	task automatic write_window(logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_WINDOW, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		restart_tracker(value[4:0]);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// wait until every item is in and every result is out
	task automatic settle();
		while (pending_reqs.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_counters.size() != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);
	endtask

	// mostly in-window sends and acks, with retransmits, stale acks and stray seqs
	task automatic queue_traffic(int count, bit noisy_tail);
		request_t r;
		int       roll;
		int       pick;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (noisy_tail && n >= count - 3) begin
				r.kind = 1'($urandom_range(1));
				r.seq = $urandom();
			end else if (roll < 4) begin
				r.kind = REQ_REMOVE;
				r.seq = $urandom();
			end else if (roll < 8) begin
				r.kind = REQ_REMOVE;
				r.seq = last_acked;
			end else if (roll < 14 && in_flight.size() != 0) begin
				r.kind = REQ_ADD;
				r.seq = in_flight[$urandom_range(in_flight.size() - 1)];
			end else if (in_flight.size() < send_window &&
					(in_flight.size() == 0 || $urandom_range(99) < 55)) begin
				r.kind = REQ_ADD;
				r.seq = next_send;
				in_flight.push_back(next_send);
				next_send++;
			end else begin
				pick = ($urandom_range(99) < 60) ? 0 : $urandom_range(in_flight.size() - 1);
				r.kind = REQ_REMOVE;
				r.seq = in_flight[pick];
				last_acked = r.seq;
				in_flight.delete(pick);
			end
			pending_reqs.push_back(r);
		end
	endtask

	initial begin
		restart_tracker(5'd16);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset window of 16: mismatched tags, retag, walks, saturation of lowest
		push_req(REQ_REMOVE, 32'd0);
		push_req(REQ_ADD, 32'd0);
		push_req(REQ_ADD, 32'd1);
		push_req(REQ_ADD, 32'd17);
		push_req(REQ_REMOVE, 32'd1);
		push_req(REQ_REMOVE, 32'd17);
		push_req(REQ_ADD, 32'd2);
		push_req(REQ_REMOVE, 32'd0);
		push_req(REQ_REMOVE, 32'd2);
		push_req(REQ_ADD, SEQ_MAX);
		push_req(REQ_REMOVE, SEQ_MAX);
		push_req(REQ_ADD, 32'd18);
		push_req(REQ_REMOVE, 32'd18);
		push_req(REQ_ADD, 32'h8000_0000);
		push_req(REQ_ADD, 32'h7FFF_FFFF);
		push_req(REQ_REMOVE, 32'h5555_5555);
		push_req(REQ_REMOVE, 32'hAAAA_AAAA);
		push_req(REQ_ADD, 32'd3);
		push_req(REQ_REMOVE, 32'd3);
		settle();

		// zero acts as a single slot
		write_window(32'd0);
		send_idle_pct = 79;
		stall_pct = 0;
		push_req(REQ_ADD, 32'd0);
		push_req(REQ_ADD, 32'd1);
		push_req(REQ_REMOVE, 32'd0);
		push_req(REQ_REMOVE, 32'd1);
		push_req(REQ_ADD, 32'd2);
		settle();
		restart_tracker(5'd0);
		write_window(32'd0);
		queue_traffic(100, 1'b1);
		settle();

		// oversize write clamps to the full table
		write_window(32'd31);
		send_idle_pct = 0;
		stall_pct = 79;
		queue_traffic(130, 1'b1);
		settle();

		// upper bits of the write are ignored
		write_window(32'hFFFF_FFE5);
		send_idle_pct = 11;
		stall_pct = 11;
		queue_traffic(130, 1'b1);
		settle();

		// sender holds off mid-stream until every result is back
		write_window(32'd16);
		send_idle_pct = 0;
		stall_pct = 0;
		queue_traffic(80, 1'b0);
		settle();
		send_idle_pct = 79;
		queue_traffic(80, 1'b1);
		settle();

		write_window(32'd3);
		send_idle_pct = 0;
		stall_pct = 79;
		queue_traffic(120, 1'b1);
		settle();

		write_window(32'($urandom_range(SLOTS, 1)));
		send_idle_pct = 11;
		stall_pct = 11;
		queue_traffic(100, 1'b1);
		settle();

		if (mismatches == 0 && expected_counters.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#(10_000_000);
		$display("%0t timeout with %0d results outstanding", $time, expected_counters.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/swst_pkg.sv
hdl/sliding_window_slot_tracker_top.sv
bench/tb_sliding_window_slot_tracker_top.sv
